@@ rtl/core/lbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared widths, register map and control types of the 3x3 LBP stream.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int PIX_W         = 8;
  localparam int FW_W          = 11;
  localparam int FH_W          = 12;
  localparam int DEF_MAX_WIDTH = 1024;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);
  localparam logic [FW_W-1:0] WIDTH_MIN    = FW_W'(3);
  localparam logic [FH_W-1:0] HEIGHT_MIN   = FH_W'(3);

  // Register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Effective frame geometry handed from the register block to the datapath
  typedef struct packed {
    logic [FW_W-1:0] width;
    logic [FH_W-1:0] height;
    logic            restart;
  } frame_cfg_t;

endpackage : lbp_pkg
`default_nettype wire

@@ rtl/core/lbp_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_cfg
// APB register block: frame width and height, clamped to their legal range.
// ----------------------------------------------------------------------------
module lbp_cfg #(
  parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lbp_pkg::APB_AW-1:0] paddr,
  input  wire logic [lbp_pkg::APB_DW-1:0] pwdata,
  output logic      [lbp_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output lbp_pkg::frame_cfg_t             cfg
);
  import lbp_pkg::*;

  localparam bit CLAMP_HI = (MAX_WIDTH < (1 << FW_W));

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic            wr_en;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = APB_DW'(frame_width);
      REG_HEIGHT: prdata = APB_DW'(frame_height);
      default:    prdata = '0;
    endcase
  end

  // Effective geometry; any write restarts the frame
  always_comb begin
    cfg.restart = wr_en;
    if (frame_width < WIDTH_MIN) begin
      cfg.width = WIDTH_MIN;
    end else if (CLAMP_HI && (frame_width > FW_W'(MAX_WIDTH))) begin
      cfg.width = FW_W'(MAX_WIDTH);
    end else begin
      cfg.width = frame_width;
    end
    cfg.height = (frame_height < HEIGHT_MIN) ? HEIGHT_MIN : frame_height;
  end

endmodule : lbp_cfg
`default_nettype wire

@@ rtl/core/lbp_line_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_line_mem
// Simple dual-port line memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lbp_line_mem #(
  parameter int DEPTH = lbp_pkg::DEF_MAX_WIDTH,
  parameter int DW    = 2 * lbp_pkg::PIX_W,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : lbp_line_mem
`default_nettype wire

@@ rtl/core/lbp_window.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_window
// 3x3 pixel window and the eight centre-to-neighbour comparisons.
// ----------------------------------------------------------------------------
module lbp_window (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      shift,
  input  wire logic [lbp_pkg::PIX_W-1:0] top,
  input  wire logic [lbp_pkg::PIX_W-1:0] mid,
  input  wire logic [lbp_pkg::PIX_W-1:0] px,
  output logic      [lbp_pkg::PIX_W-1:0] code
);
  import lbp_pkg::*;

  // Row-major, row 0 oldest line, column 2 newest
  logic [PIX_W-1:0] win      [9];
  logic [PIX_W-1:0] win_next [9];
  logic [PIX_W-1:0] ctr;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k*3+0] = win[k*3+1];
      win_next[k*3+1] = win[k*3+2];
    end
    win_next[2] = top;
    win_next[5] = mid;
    win_next[8] = px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (shift) begin
      win <= win_next;
    end
  end

  // Code of the window as it stands after this shift
  assign ctr = win_next[4];
  always_comb begin
    code[7] = (ctr <= win_next[0]);
    code[6] = (ctr <= win_next[1]);
    code[5] = (ctr <= win_next[2]);
    code[4] = (ctr <= win_next[5]);
    code[3] = (ctr <= win_next[8]);
    code[2] = (ctr <= win_next[7]);
    code[1] = (ctr <= win_next[6]);
    code[0] = (ctr <= win_next[3]);
  end

endmodule : lbp_window
`default_nettype wire

@@ rtl/core/lbp_3x3_stream.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_3x3_stream
// Streaming 3x3 local binary pattern over a raster-order grayscale frame.
// ----------------------------------------------------------------------------
//
//   port group   dir   handshake                payload
//   ----------   ---   ----------------------   ----------------------------
//   input        in    in_valid / in_stall      pixel
//   output       out   out_valid / out_stall    lbp_code, row_last, frame_last
//   config       in    APB psel/penable/pready  paddr, pwdata, prdata
//
// One pixel is taken every clock while the output is not held. A request
// enters stage 0 (counters, line-memory read), moves to stage 1 in the next
// cycle (read data back, window shift, line-memory write-back) and then
// lands in the output register. The rate is set by the line memory, read
// once and written once per pixel at distinct columns. Reset is synchronous;
// it clears counters, window and valid flags. The line memory is not
// cleared: rows 0 and 1 fill it before any code is produced. A held output
// stalls stage 1, and stage 1 in turn stalls the input; border pixels that
// produce no code pass stage 1 even while the output is held.
// ----------------------------------------------------------------------------
module lbp_3x3_stream #(
  parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // pixel input
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [lbp_pkg::PIX_W-1:0]  pixel,
  // code output
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [lbp_pkg::PIX_W-1:0]  lbp_code,
  output logic                            row_last,
  output logic                            frame_last,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lbp_pkg::APB_AW-1:0] paddr,
  input  wire logic [lbp_pkg::APB_DW-1:0] pwdata,
  output logic      [lbp_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import lbp_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = (COL_W > FW_W) ? COL_W : FW_W;

  frame_cfg_t cfg;

  // Stage 0: position counters
  logic [COL_W-1:0] column_count;
  logic [COL_W-1:0] column_count_next;
  logic [FH_W-1:0]  row_count;
  logic [FH_W-1:0]  row_count_next;
  logic             col_end;
  logic             row_end;
  logic             accept;

  // Stage 1: request waiting for its line-memory data
  logic             s1_valid;
  logic             s1_emit;
  logic             s1_row_last;
  logic             s1_frame_last;
  logic [PIX_W-1:0] s1_pixel;
  logic [COL_W-1:0] s1_col;
  logic             s1_advance;

  logic [2*PIX_W-1:0] mem_rd_data;
  logic [PIX_W-1:0]   code_next;

  lbp_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 1 moves on when it has no code to deliver or the output slot frees up
  assign s1_advance = s1_valid && (!s1_emit || !out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign accept     = in_valid && !in_stall;

  // Last column and last row of the input frame
  assign col_end = (CMP_W'(column_count) == CMP_W'(cfg.width) - CMP_W'(1));
  assign row_end = (row_count == cfg.height - FH_W'(1));

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept) begin
      if (col_end) begin
        column_count_next = '0;
        row_count_next    = row_end ? '0 : row_count + FH_W'(1);
      end else begin
        column_count_next = column_count + COL_W'(1);
      end
    end
  end

  // Advance the raster position; any register write restarts the frame
  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the request; a code exists only once rows 0-1 and columns 0-1 are past
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel      <= pixel;
      s1_col        <= column_count;
      s1_emit       <= (row_count > FH_W'(1)) && (column_count > COL_W'(1));
      s1_row_last   <= col_end;
      s1_frame_last <= col_end && row_end;
    end
  end

  // Word layout: upper line in the high byte, middle line in the low byte.
  // Read at stage 0, write back at stage 1. Only one request sits in stage 1
  // and the width is at least three, so a read never meets a pending write.
  lbp_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PIX_W),
    .AW    (COL_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (mem_rd_data),
    .wr_en   (s1_advance),
    .wr_addr (s1_col),
    .wr_data ({mem_rd_data[PIX_W-1:0], s1_pixel})
  );

  lbp_window u_window (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_advance),
    .top   (mem_rd_data[2*PIX_W-1:PIX_W]),
    .mid   (mem_rd_data[PIX_W-1:0]),
    .px    (s1_pixel),
    .code  (code_next)
  );

  // Output register: load a fresh code, else drop the one just taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_emit) begin
      lbp_code   <= code_next;
      row_last   <= s1_row_last;
      frame_last <= s1_frame_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_frame_last_ends_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!frame_last || row_last))
    else $error("frame end mark without row end mark");

  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with stage 1 empty");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request missing from stage 1");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(column_count) < CMP_W'(cfg.width))
    else $error("column counter beyond frame width");

  a_no_code_lost: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(s1_advance && s1_emit))
    else $error("held code overwritten");
`endif

endmodule : lbp_3x3_stream
`default_nettype wire
